FILE: design/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared constants, state codes and helpers for the triangle strip builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tsb_pkg;

  localparam int unsigned NumFacesDef   = 32;
  localparam int unsigned VertexBitsDef = 16;

  // Input field widths fixed by the interface
  localparam int unsigned FaceIdxW  = 5;
  localparam int unsigned NeighborW = 6;
  localparam int unsigned EdgeW     = 2;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STRIP = 1'b1;

  // Controller states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RDSTART = 3'd1;
  localparam logic [2:0] ST_CHECK   = 3'd2;
  localparam logic [2:0] ST_WALKRD  = 3'd3;
  localparam logic [2:0] ST_ISSUE   = 3'd4;
  localparam logic [2:0] ST_SHOW    = 3'd5;

  // Output sections
  localparam logic [1:0] SEC_DUP   = 2'd0;
  localparam logic [1:0] SEC_REV   = 2'd1;
  localparam logic [1:0] SEC_START = 2'd2;
  localparam logic [1:0] SEC_FWD   = 2'd3;

  // Reduce a two-bit edge or corner code modulo three
  function automatic logic [1:0] mod3(input logic [1:0] v);
    logic [1:0] r;
    r = (v == 2'd3) ? 2'd0 : v;
    return r;
  endfunction

  // (a + b) mod 3 for a, b in 0..2
  function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/tsb_ram.sv
// ----------------------------------------------------------------------------
// tsb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/triangle_strip_builder.sv
// ----------------------------------------------------------------------------
// triangle_strip_builder
// Greedy triangle strip generation over a face table held in RAM.
// ----------------------------------------------------------------------------
// A load is written to the face table while idle. A strip command claims F
// faces walking forward and R walking backward and produces V = R + (R odd) +
// 3 + F vertices: each walk step is one read of the face table, whose row is
// used in the walk-read state, and each vertex is read from a list RAM or
// from the start registers and then shown for one cycle. busy stays high
// for the whole strip command; a load does not raise it. Results cannot be
// held off: each vertex is on strip_vertex_o for exactly one cycle with
// result_valid_o high, and last_o marks the final one.
`default_nettype none

module triangle_strip_builder #(
  parameter int unsigned NUM_FACES   = tsb_pkg::NumFacesDef,
  parameter int unsigned VERTEX_BITS = tsb_pkg::VertexBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            cmd_i,
  input  wire logic [tsb_pkg::FaceIdxW-1:0]    face_index_i,
  input  wire logic [VERTEX_BITS-1:0]          vertex_a_i,
  input  wire logic [VERTEX_BITS-1:0]          vertex_b_i,
  input  wire logic [VERTEX_BITS-1:0]          vertex_c_i,
  input  wire logic [tsb_pkg::NeighborW-1:0]   neighbor_a_i,
  input  wire logic [tsb_pkg::NeighborW-1:0]   neighbor_b_i,
  input  wire logic [tsb_pkg::NeighborW-1:0]   neighbor_c_i,
  input  wire logic [tsb_pkg::EdgeW-1:0]       entry_edge_a_i,
  input  wire logic [tsb_pkg::EdgeW-1:0]       entry_edge_b_i,
  input  wire logic [tsb_pkg::EdgeW-1:0]       entry_edge_c_i,
  input  wire logic [tsb_pkg::EdgeW-1:0]       start_vert_i,
  output logic                                 result_valid_o,
  output logic [VERTEX_BITS-1:0]               strip_vertex_o,
  output logic                                 last_o
);

  import tsb_pkg::*;

  localparam int unsigned FAW    = (NUM_FACES > 1) ? $clog2(NUM_FACES) : 1;
  localparam int unsigned CW     = $clog2(NUM_FACES + 1);
  localparam int unsigned VB     = VERTEX_BITS;
  localparam int unsigned NB_OFF = 3 * VB;
  localparam int unsigned ED_OFF = NB_OFF + 3 * NeighborW;
  localparam int unsigned ROW_W  = ED_OFF + 3 * EdgeW;
  localparam int unsigned LIST_D = 2 * (2 ** FAW);

  logic [2:0]             state_q, state_d;
  logic [NUM_FACES-1:0]   free_q, free_d;
  logic [ROW_W-1:0]       row_q, row_d, start_row_q, start_row_d;
  logic [1:0]             edge_q, edge_d, ine_q, ine_d, sv_q, sv_d;
  logic                   add_one_q, add_one_d, rev_q, rev_d;
  logic [CW-1:0]          cnt_q, cnt_d, nf_q, nf_d, eidx_q, eidx_d;
  logic [1:0]             sec_q, sec_d;
  logic [VB-1:0]          s_q [3];
  logic [VB-1:0]          s_d [3];

  // Face table
  logic                   face_we;
  logic [FAW-1:0]         face_waddr, face_raddr;
  logic [ROW_W-1:0]       face_wdata, face_rdata;

  // Walk lists: forward list in the lower half, reverse list in the upper half
  logic                   list_we;
  logic [FAW:0]           list_waddr, list_raddr;
  logic [VB-1:0]          list_wdata, list_rdata;

  logic                   accept, in_range;
  logic [NeighborW-1:0]   nb_sel;
  logic [1:0]             in_edge_sel;
  logic                   claim;

  tsb_ram #(.Width(ROW_W), .Depth(NUM_FACES)) u_face_ram (
    .clk_i   (clk_i),
    .we_i    (face_we),
    .waddr_i (face_waddr),
    .wdata_i (face_wdata),
    .raddr_i (face_raddr),
    .rdata_o (face_rdata)
  );

  tsb_ram #(.Width(VB), .Depth(LIST_D)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (int'(face_index_i) < int'(NUM_FACES));

  assign face_we    = accept && in_range && (cmd_i == CMD_LOAD);
  assign face_waddr = FAW'(face_index_i);
  assign face_wdata = {mod3(entry_edge_c_i), mod3(entry_edge_b_i), mod3(entry_edge_a_i),
                       neighbor_c_i, neighbor_b_i, neighbor_a_i,
                       vertex_c_i, vertex_b_i, vertex_a_i};

  assign nb_sel      = row_q[NB_OFF + int'(edge_q) * NeighborW +: NeighborW];
  assign in_edge_sel = row_q[ED_OFF + int'(edge_q) * EdgeW +: EdgeW];
  assign claim       = (int'(nb_sel) < int'(NUM_FACES)) && free_q[FAW'(nb_sel)]
                       && (int'(cnt_q) < int'(NUM_FACES));

  assign face_raddr = (state_q == ST_IDLE) ? FAW'(face_index_i) : FAW'(nb_sel);

  assign list_waddr = {rev_q, FAW'(cnt_q)};
  assign list_wdata = face_rdata[int'(ine_q) * VB +: VB];
  assign list_we    = (state_q == ST_WALKRD);
  assign list_raddr = {(sec_q != SEC_FWD), FAW'(eidx_q)};

  always_comb begin
    state_d     = state_q;
    free_d      = free_q;
    row_d       = row_q;
    start_row_d = start_row_q;
    edge_d      = edge_q;
    ine_d       = ine_q;
    sv_d        = sv_q;
    add_one_d   = add_one_q;
    rev_d       = rev_q;
    cnt_d       = cnt_q;
    nf_d        = nf_q;
    eidx_d      = eidx_q;
    sec_d       = sec_q;
    s_d         = s_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_range) begin
          if (cmd_i == CMD_LOAD) begin
            free_d[FAW'(face_index_i)] = 1'b1;
          end else begin
            free_d[FAW'(face_index_i)] = 1'b0;
            sv_d    = mod3(start_vert_i);
            state_d = ST_RDSTART;
          end
        end
      end
      ST_RDSTART: begin
        s_d[0]      = face_rdata[int'(sv_q) * VB +: VB];
        s_d[1]      = face_rdata[int'(add_mod3(sv_q, 2'd1)) * VB +: VB];
        s_d[2]      = face_rdata[int'(add_mod3(sv_q, 2'd2)) * VB +: VB];
        row_d       = face_rdata;
        start_row_d = face_rdata;
        edge_d      = sv_q;
        add_one_d   = 1'b0;
        rev_d       = 1'b0;
        cnt_d       = '0;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        if (claim) begin
          free_d[FAW'(nb_sel)] = 1'b0;
          ine_d   = in_edge_sel;
          state_d = ST_WALKRD;
        end else if (!rev_q) begin
          // Forward walk done: restart from the start face for the reverse walk
          nf_d      = cnt_q;
          cnt_d     = '0;
          rev_d     = 1'b1;
          row_d     = start_row_q;
          edge_d    = add_mod3(sv_q, 2'd2);
          add_one_d = 1'b1;
        end else begin
          state_d = ST_ISSUE;
          if (cnt_q[0]) begin
            sec_d  = SEC_DUP;
            eidx_d = cnt_q - CW'(1);
          end else if (cnt_q != '0) begin
            sec_d  = SEC_REV;
            eidx_d = cnt_q - CW'(1);
          end else begin
            sec_d  = SEC_START;
            eidx_d = '0;
          end
        end
      end
      ST_WALKRD: begin
        cnt_d     = cnt_q + CW'(1);
        row_d     = face_rdata;
        edge_d    = add_mod3(ine_q, add_one_q ? 2'd1 : 2'd2);
        add_one_d = !add_one_q;
        state_d   = ST_CHECK;
      end
      ST_ISSUE: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        state_d = ST_ISSUE;
        unique case (sec_q)
          SEC_DUP: begin
            sec_d = SEC_REV;
          end
          SEC_REV: begin
            if (eidx_q == '0) begin
              sec_d = SEC_START;
            end else begin
              eidx_d = eidx_q - CW'(1);
            end
          end
          SEC_START: begin
            if (eidx_q == CW'(2)) begin
              if (nf_q == '0) begin
                state_d = ST_IDLE;
              end else begin
                sec_d  = SEC_FWD;
                eidx_d = '0;
              end
            end else begin
              eidx_d = eidx_q + CW'(1);
            end
          end
          SEC_FWD: begin
            if (eidx_q == nf_q - CW'(1)) begin
              state_d = ST_IDLE;
            end else begin
              eidx_d = eidx_q + CW'(1);
            end
          end
          default: ;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    result_valid_o = (state_q == ST_SHOW);
    unique case (sec_q)
      SEC_DUP, SEC_REV: strip_vertex_o = list_rdata;
      SEC_START:        strip_vertex_o = s_q[eidx_q[1:0]];
      SEC_FWD:          strip_vertex_o = list_rdata;
      default:          strip_vertex_o = list_rdata;
    endcase
    last_o = result_valid_o &&
             (((sec_q == SEC_START) && (eidx_q == CW'(2)) && (nf_q == '0)) ||
              ((sec_q == SEC_FWD) && (eidx_q == nf_q - CW'(1))));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      free_q    <= '0;
      add_one_q <= 1'b0;
      rev_q     <= 1'b0;
      cnt_q     <= '0;
      nf_q      <= '0;
      eidx_q    <= '0;
      sec_q     <= SEC_DUP;
    end else begin
      state_q   <= state_d;
      free_q    <= free_d;
      add_one_q <= add_one_d;
      rev_q     <= rev_d;
      cnt_q     <= cnt_d;
      nf_q      <= nf_d;
      eidx_q    <= eidx_d;
      sec_q     <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    start_row_q <= start_row_d;
    edge_q      <= edge_d;
    ine_q       <= ine_d;
    sv_q        <= sv_d;
    s_q         <= s_d;
  end

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result shown while idle");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o) else $error("last without result");

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe held two cycles");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !busy) else $error("busy after final vertex");

  a_strip_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_range && (cmd_i == CMD_STRIP)) |=> busy)
    else $error("strip command not started");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for triangle_strip_builder. A directed table loads
// isolated faces and a small connected mesh, then builds strips from them.
// A random part follows: batches of face loads wired mostly among themselves,
// each followed by strips. Every strip vertex is checked in order against a
// local model of the greedy forward and backward walk, or against typed table values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tsb_pkg::*;

  localparam int unsigned NFaces    = 32;
  localparam int unsigned FwdDepth  = NFaces + 3;
  localparam int unsigned NumItems  = 460;
  localparam int unsigned IdleLimit = 5000;

  typedef struct packed {
    logic [15:0] vert;
    logic        last;
  } strip_vert_t;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  face;
    logic [15:0] va, vb, vc;
    logic [5:0]  na, nb, nc;
    logic [1:0]  ea, eb, ec;
    logic [1:0]  sv;
    logic        typed;
    logic [15:0] t0, t1, t2;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd_i = 1'b0;
  logic [4:0]  face_index_i = '0;
  logic [15:0] vertex_a_i = '0, vertex_b_i = '0, vertex_c_i = '0;
  logic [5:0]  neighbor_a_i = '0, neighbor_b_i = '0, neighbor_c_i = '0;
  logic [1:0]  entry_edge_a_i = '0, entry_edge_b_i = '0, entry_edge_c_i = '0;
  logic [1:0]  start_vert_i = '0;
  logic        result_valid_o;
  logic [15:0] strip_vertex_o;
  logic        last_o;

  // model copy of the face table
  logic [15:0] corner_tbl[NFaces][3];
  logic [5:0]  nbr_tbl[NFaces][3];
  int unsigned entry_tbl[NFaces][3];
  bit          free_tbl[NFaces];
  bit          loaded[NFaces];

  strip_vert_t pending_verts[$];
  dir_row_t    dir_tbl[18];
  int unsigned errors = 0, idle_cycles = 0;
  int unsigned n_loads = 0, n_strips = 0, n_verts = 0, longest = 0;
  bit          burst = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  triangle_strip_builder i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .face_index_i,
    .vertex_a_i, .vertex_b_i, .vertex_c_i,
    .neighbor_a_i, .neighbor_b_i, .neighbor_c_i,
    .entry_edge_a_i, .entry_edge_b_i, .entry_edge_c_i,
    .start_vert_i, .result_valid_o, .strip_vertex_o, .last_o
  );

  // Claim free neighbors starting at face cur through edge e.
  function automatic void claim_walk(int unsigned cur, int unsigned e, bit add_one,
                                     int unsigned depth, ref logic [15:0] lst[$]);
    int unsigned nxt, ie;
    nxt = nbr_tbl[cur][e];
    while (nxt < NFaces && free_tbl[nxt] && lst.size() < depth) begin
      ie = entry_tbl[cur][e];
      cur = nxt;
      lst.insert(lst.size(), corner_tbl[cur][ie]);
      free_tbl[cur] = 1'b0;
      e = (ie + (add_one ? 1 : 2)) % 3;
      add_one = !add_one;
      nxt = nbr_tbl[cur][e];
    end
  endfunction

  function automatic void build_strip(int unsigned f, int unsigned sv,
                                      ref strip_vert_t res[$]);
    logic [15:0] fwd[$];
    logic [15:0] rev[$];
    strip_vert_t v;
    free_tbl[f] = 1'b0;
    fwd = '{corner_tbl[f][sv], corner_tbl[f][(sv + 1) % 3], corner_tbl[f][(sv + 2) % 3]};
    rev = {};
    claim_walk(f, sv, 1'b0, FwdDepth, fwd);
    claim_walk(f, (sv + 2) % 3, 1'b1, NFaces, rev);
    res = {};
    v.last = 1'b0;
    if (rev.size() % 2 == 1) begin
      v.vert = rev[rev.size() - 1];
      res.insert(res.size(), v);
    end
    for (int i = rev.size(); i > 0; i--) begin
      v.vert = rev[i - 1];
      res.insert(res.size(), v);
    end
    foreach (fwd[i]) begin
      v.vert = fwd[i];
      res.insert(res.size(), v);
    end
    res[res.size() - 1].last = 1'b1;
  endfunction

  // Hold or drop start for a random gap, then present one item and wait for
  // its transfer. Called at a rising edge.
  task automatic issue(dir_row_t r);
    int unsigned gap, sel, sv;
    strip_vert_t res[$];
    strip_vert_t v;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 29) == 0) burst = !burst;
    gap = burst ? 0 : (sel < 40) ? 0 : (sel < 85) ? $urandom_range(1, 3)
                                                  : $urandom_range(5, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i <= r.cmd;        face_index_i <= r.face;
    vertex_a_i <= r.va;    vertex_b_i <= r.vb;    vertex_c_i <= r.vc;
    neighbor_a_i <= r.na;  neighbor_b_i <= r.nb;  neighbor_c_i <= r.nc;
    entry_edge_a_i <= r.ea; entry_edge_b_i <= r.eb; entry_edge_c_i <= r.ec;
    start_vert_i <= r.sv;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (r.cmd == CMD_LOAD) begin
      corner_tbl[r.face] = '{r.va, r.vb, r.vc};
      nbr_tbl[r.face] = '{r.na, r.nb, r.nc};
      entry_tbl[r.face] = '{r.ea % 3, r.eb % 3, r.ec % 3};
      free_tbl[r.face] = 1'b1;
      loaded[r.face] = 1'b1;
      n_loads++;
    end else begin
      sv = r.sv % 3;
      build_strip(r.face, sv, res);
      if (r.typed) begin
        res = {};
        v.last = 1'b0;
        v.vert = r.t0; res.insert(res.size(), v);
        v.vert = r.t1; res.insert(res.size(), v);
        v.vert = r.t2; v.last = 1'b1; res.insert(res.size(), v);
      end
      foreach (res[i]) pending_verts.insert(pending_verts.size(), res[i]);
      if (res.size() > longest) longest = res.size();
      n_strips++;
    end
  endtask

  always @(posedge clk_i) begin
    strip_vert_t exp_v;
    if (rst_ni && result_valid_o) begin
      if (pending_verts.size() == 0) begin
        $error("unexpected vertex %h last %b", strip_vertex_o, last_o);
        errors++;
      end else begin
        exp_v = pending_verts.pop_front();
        n_verts++;
        if (strip_vertex_o !== exp_v.vert) begin
          $error("strip_vertex: expected %h, actual %h", exp_v.vert, strip_vertex_o);
          errors++;
        end
        if (last_o !== exp_v.last) begin
          $error("last: expected %b, actual %b", exp_v.last, last_o);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t    r;
    int unsigned items, k, pick;
    int unsigned batch[$];
    dir_tbl = '{
      '{CMD_LOAD,  5'd0, 16'h0000, 16'hffff, 16'h1234, 6'd63, 6'd32, 6'd40,
        2'd3, 2'd3, 2'd3, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_STRIP, 5'd0, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0, 6'd0,
        2'd0, 2'd0, 2'd0, 2'd0, 1'b1, 16'h0000, 16'hffff, 16'h1234},
      '{CMD_STRIP, 5'd0, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0, 6'd0,
        2'd0, 2'd0, 2'd0, 2'd3, 1'b1, 16'h0000, 16'hffff, 16'h1234},
      '{CMD_STRIP, 5'd0, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0, 6'd0,
        2'd0, 2'd0, 2'd0, 2'd2, 1'b1, 16'h1234, 16'h0000, 16'hffff},
      '{CMD_LOAD,  5'd31, 16'hffff, 16'hffff, 16'hffff, 6'd32, 6'd32, 6'd32,
        2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_STRIP, 5'd31, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0, 6'd0,
        2'd0, 2'd0, 2'd0, 2'd1, 1'b1, 16'hffff, 16'hffff, 16'hffff},
      '{CMD_LOAD,  5'd1, 16'd10, 16'd11, 16'd12, 6'd2, 6'd3, 6'd33,
        2'd0, 2'd1, 2'd2, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_LOAD,  5'd2, 16'd20, 16'd21, 16'd22, 6'd1, 6'd4, 6'd32,
        2'd0, 2'd2, 2'd0, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_LOAD,  5'd3, 16'd30, 16'd31, 16'd32, 6'd5, 6'd1, 6'd2,
        2'd1, 2'd1, 2'd3, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_LOAD,  5'd4, 16'd40, 16'd41, 16'd42, 6'd32, 6'd2, 6'd3,
        2'd0, 2'd1, 2'd2, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_LOAD,  5'd5, 16'd50, 16'd51, 16'd52, 6'd3, 6'd6, 6'd32,
        2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_LOAD,  5'd6, 16'd60, 16'd61, 16'd62, 6'd5, 6'd5, 6'd1,
        2'd1, 2'd2, 2'd0, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_STRIP, 5'd1, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0, 6'd0,
        2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_STRIP, 5'd4, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0, 6'd0,
        2'd0, 2'd0, 2'd0, 2'd2, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_STRIP, 5'd6, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0, 6'd0,
        2'd0, 2'd0, 2'd0, 2'd1, 1'b0, 16'h0, 16'h0, 16'h0},
      // a face that is its own neighbor is already used when reached
      '{CMD_LOAD,  5'd7, 16'd70, 16'd71, 16'd72, 6'd7, 6'd7, 6'd7,
        2'd0, 2'd1, 2'd2, 2'd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{CMD_STRIP, 5'd7, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0, 6'd0,
        2'd0, 2'd0, 2'd0, 2'd1, 1'b1, 16'd71, 16'd72, 16'd70},
      '{CMD_STRIP, 5'd3, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0, 6'd0,
        2'd0, 2'd0, 2'd0, 2'd3, 1'b0, 16'h0, 16'h0, 16'h0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) issue(dir_tbl[i]);
    items = 18;

    while (items < NumItems) begin
      // load a batch wired mostly among itself, then build strips over it
      k = $urandom_range(2, 12);
      batch = {};
      repeat (k) batch.insert(batch.size(), $urandom_range(0, NFaces - 1));
      foreach (batch[i]) begin
        r = '0;
        r.cmd = CMD_LOAD;
        r.face = 5'(batch[i]);
        r.va = 16'($urandom); r.vb = 16'($urandom); r.vc = 16'($urandom);
        r.na = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'(batch[$urandom_range(0, k - 1)]);
        r.nb = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'(batch[$urandom_range(0, k - 1)]);
        r.nc = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'(batch[$urandom_range(0, k - 1)]);
        r.ea = 2'($urandom_range(0, 3)); r.eb = 2'($urandom_range(0, 3));
        r.ec = 2'($urandom_range(0, 3));
        r.sv = 2'($urandom_range(0, 3));
        issue(r);
        items++;
      end
      repeat ($urandom_range(1, 3)) begin
        r = '0;
        r.cmd = CMD_STRIP;
        r.face = 5'(batch[$urandom_range(0, k - 1)]);
        // now and then restart from any face loaded earlier
        if ($urandom_range(0, 4) == 0) begin
          pick = $urandom_range(0, NFaces - 1);
          if (loaded[pick]) r.face = 5'(pick);
        end
        r.va = 16'($urandom); r.na = 6'($urandom); r.ea = 2'($urandom);
        r.sv = 2'($urandom_range(0, 3));
        issue(r);
        items++;
      end
    end
    start <= 1'b0;

    do @(posedge clk_i); while (pending_verts.size() != 0 || busy);
    repeat (20) @(posedge clk_i);
    if (pending_verts.size() != 0) begin
      $error("%0d vertices never arrived", pending_verts.size());
      errors++;
    end
    $display("Ran %0d face loads and %0d strips; %0d vertices checked, longest strip %0d.",
             n_loads, n_strips, n_verts, longest);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
